@@ rtl/assert_macros.svh @@
// shared assertion forms, clocked on i_clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/bhm_pkg.sv @@
`default_nettype none

package bhm_pkg;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctrl;

    typedef struct packed {
        logic found;
        logic bucket_full;
    } t_flags;

endpackage

`default_nettype wire

@@ rtl/bucketed_hash_map.sv @@
// the bucket index is the low key bits when NUM_BUCKETS is a power of two, otherwise
// a remainder computed four key bits per cycle; the bucket row is then read, and the
// result is registered while any changed row is written back on the table port
// input is stalled until the previous item's result is registered at the output
// reset: synchronous, active low; a clearing pass over all NUM_BUCKETS rows follows,
// during which input is stalled
`default_nettype none

`include "assert_macros.svh"

module bucketed_hash_map
    import bhm_pkg::*;
#(
    parameter int NUM_BUCKETS = 4096,
    parameter int WAYS        = 4,
    parameter int KEY_BITS    = 20,
    parameter int VALUE_BITS  = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_found,
    output logic [VALUE_BITS-1:0]      o_read_value,
    output logic                       o_bucket_full
);

    localparam int BKT_BITS = $clog2(NUM_BUCKETS);
    localparam int ROW_W    = WAYS * (1 + KEY_BITS + VALUE_BITS);

    t_state                        r_state;
    t_state                        n_state;
    t_cmd                          r_cmd;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_value;
    logic [BKT_BITS-1:0]           r_bucket;
    logic                          r_out_valid;
    logic                          r_found;
    logic [VALUE_BITS-1:0]         r_read_value;
    logic                          r_bucket_full;

    logic                          in_acc;
    logic                          out_free;
    logic                          load_out;
    t_tbl_ctrl                     ctrl;
    logic [BKT_BITS-1:0]           tbl_addr;
    logic [ROW_W-1:0]              tbl_rd_data;
    logic [ROW_W-1:0]              tbl_wr_data;
    logic                          tbl_clr_busy;
    logic [BKT_BITS-1:0]           mod_bucket;
    logic                          mod_done;

    logic [WAYS-1:0]               rd_valid;
    logic [WAYS-1:0][KEY_BITS-1:0] rd_keys;
    logic [WAYS-1:0][VALUE_BITS-1:0] rd_vals;
    logic [WAYS-1:0]               wr_valid;
    logic [WAYS-1:0][KEY_BITS-1:0] wr_keys;
    logic [WAYS-1:0][VALUE_BITS-1:0] wr_vals;
    logic                          match_wr;
    t_flags                        match_flags;
    logic [VALUE_BITS-1:0]         match_value;

    assign o_stall  = (r_state != ST_IDLE) || tbl_clr_busy;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    bhm_mod #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .KEY_BITS    (KEY_BITS)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_key    (i_key),
        .o_bucket (mod_bucket),
        .o_done   (mod_done)
    );

    bhm_table #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .ROW_W       (ROW_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_addr     (tbl_addr),
        .i_wr_data  (tbl_wr_data),
        .o_rd_data  (tbl_rd_data),
        .o_clr_busy (tbl_clr_busy)
    );

    assign {rd_valid, rd_keys, rd_vals} = tbl_rd_data;
    assign tbl_wr_data = {wr_valid, wr_keys, wr_vals};

    bhm_match #(
        .WAYS       (WAYS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_match (
        .i_cmd        (r_cmd),
        .i_key        (r_key),
        .i_value      (r_value),
        .i_valid_row  (rd_valid),
        .i_key_row    (rd_keys),
        .i_value_row  (rd_vals),
        .o_valid_row  (wr_valid),
        .o_key_row    (wr_keys),
        .o_value_row  (wr_vals),
        .o_wr_en      (match_wr),
        .o_flags      (match_flags),
        .o_read_value (match_value)
    );

    always_comb begin
        n_state  = r_state;
        ctrl     = '0;
        tbl_addr = mod_bucket;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (mod_done) begin
                        ctrl.rd_en = 1'b1;
                        n_state    = ST_LOOK;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    ctrl.rd_en = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                tbl_addr = r_bucket;
                if (out_free) begin
                    ctrl.wr_en = match_wr;
                    load_out   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (ctrl.rd_en) begin
            r_bucket <= mod_bucket;
        end
        if (load_out) begin
            r_found       <= match_flags.found;
            r_bucket_full <= match_flags.bucket_full;
            r_read_value  <= match_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_bucket_full = r_bucket_full;

    `AST_NEXT(a_rd_then_look, ctrl.rd_en, r_state == ST_LOOK)
    `AST_IMPL(a_idle_in_clear, tbl_clr_busy, r_state == ST_IDLE && !ctrl.wr_en)
    `AST_IMPL(a_flags_excl, r_out_valid, !(r_found && r_bucket_full))

endmodule

`default_nettype wire

@@ rtl/bhm_mod.sv @@
`default_nettype none

`include "assert_macros.svh"

module bhm_mod
    import bhm_pkg::*;
#(
    parameter int NUM_BUCKETS = 4096,
    parameter int KEY_BITS    = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [KEY_BITS-1:0]            i_key,
    output logic      [$clog2(NUM_BUCKETS)-1:0] o_bucket,
    output logic                                o_done
);

    localparam int BKT_BITS = $clog2(NUM_BUCKETS);
    localparam int EXT_BITS = (KEY_BITS > BKT_BITS) ? KEY_BITS : BKT_BITS;
    localparam int DIG_BITS = 4;
    localparam int STEPS    = (KEY_BITS + DIG_BITS - 1) / DIG_BITS;
    localparam int PAD_BITS = STEPS * DIG_BITS;
    localparam int CNT_BITS = $clog2(STEPS + 1);
    localparam int SH_BITS  = BKT_BITS + DIG_BITS;

    generate
        if (NUM_BUCKETS == (1 << BKT_BITS)) begin : g_pow2
            logic [EXT_BITS-1:0] key_ext;

            // low key bits select the bucket
            assign key_ext  = EXT_BITS'(i_key);
            assign o_bucket = key_ext[BKT_BITS-1:0];
            assign o_done   = i_start;
        end else begin : g_iter
            logic [PAD_BITS-1:0] r_key;
            logic [BKT_BITS-1:0] r_rem;
            logic [CNT_BITS-1:0] r_cnt;
            logic                r_busy;
            logic                r_done;
            logic [SH_BITS-1:0]  rem_sh;
            logic [SH_BITS-1:0]  rem_nx;

            // remainder by compare and subtract, four key bits per cycle
            always_comb begin
                rem_sh = {r_rem, r_key[PAD_BITS-1 -: DIG_BITS]};
                rem_nx = rem_sh;
                for (int q = 1; q < (1 << DIG_BITS); q++) begin
                    if (rem_sh >= SH_BITS'(q * NUM_BUCKETS)) begin
                        rem_nx = rem_sh - SH_BITS'(q * NUM_BUCKETS);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                    end else if (r_busy && r_cnt == CNT_BITS'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= PAD_BITS'(i_key);
                    r_rem <= '0;
                    r_cnt <= CNT_BITS'(STEPS);
                end else if (r_busy) begin
                    r_key <= r_key << DIG_BITS;
                    r_rem <= rem_nx[BKT_BITS-1:0];
                    r_cnt <= r_cnt - CNT_BITS'(1);
                end
            end

            assign o_bucket = r_rem;
            assign o_done   = r_done;

            `AST_IMPL(a_rem_range, r_done, r_rem < BKT_BITS'(NUM_BUCKETS))
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/bhm_table.sv @@
`default_nettype none

`include "assert_macros.svh"

module bhm_table
    import bhm_pkg::*;
#(
    parameter int NUM_BUCKETS = 4096,
    parameter int ROW_W       = 164
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_tbl_ctrl                      i_ctrl,
    input  wire logic [$clog2(NUM_BUCKETS)-1:0] i_addr,
    input  wire logic [ROW_W-1:0]               i_wr_data,
    output logic      [ROW_W-1:0]               o_rd_data,
    output logic                                o_clr_busy
);

    localparam int BKT_BITS = $clog2(NUM_BUCKETS);

    logic [ROW_W-1:0]    r_mem [NUM_BUCKETS];
    logic [ROW_W-1:0]    r_rd_data;
    logic [BKT_BITS-1:0] r_clr_cnt;
    logic                r_clr_busy;

    // clearing pass after reset, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + BKT_BITS'(1);
            if (r_clr_cnt == BKT_BITS'(NUM_BUCKETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

    `AST_IMPL(a_clr_end, $fell(r_clr_busy), $past(r_clr_cnt) == BKT_BITS'(NUM_BUCKETS - 1))

endmodule

`default_nettype wire

@@ rtl/bhm_match.sv @@
`default_nettype none

module bhm_match
    import bhm_pkg::*;
#(
    parameter int WAYS       = 4,
    parameter int KEY_BITS   = 20,
    parameter int VALUE_BITS = 20
) (
    input  wire t_cmd                               i_cmd,
    input  wire logic [KEY_BITS-1:0]                i_key,
    input  wire logic [VALUE_BITS-1:0]              i_value,
    input  wire logic [WAYS-1:0]                    i_valid_row,
    input  wire logic [WAYS-1:0][KEY_BITS-1:0]      i_key_row,
    input  wire logic [WAYS-1:0][VALUE_BITS-1:0]    i_value_row,
    output logic      [WAYS-1:0]                    o_valid_row,
    output logic      [WAYS-1:0][KEY_BITS-1:0]      o_key_row,
    output logic      [WAYS-1:0][VALUE_BITS-1:0]    o_value_row,
    output logic                                    o_wr_en,
    output t_flags                                  o_flags,
    output logic      [VALUE_BITS-1:0]              o_read_value
);

    logic [WAYS-1:0]       raw_hit;
    logic [WAYS-1:0]       raw_free;
    logic [WAYS-1:0]       hit_oh;
    logic [WAYS-1:0]       free_oh;
    logic                  hit;
    logic                  have_free;
    logic [VALUE_BITS-1:0] hit_value;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            raw_hit[w]  = i_valid_row[w] && (i_key_row[w] == i_key);
            raw_free[w] = !i_valid_row[w];
        end
        // lowest way wins
        hit_oh    = raw_hit & (~raw_hit + WAYS'(1));
        free_oh   = raw_free & (~raw_free + WAYS'(1));
        hit       = |raw_hit;
        have_free = |raw_free;
        hit_value = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_value = hit_value | ({VALUE_BITS{hit_oh[w]}} & i_value_row[w]);
        end
    end

    always_comb begin
        o_valid_row  = i_valid_row;
        o_key_row    = i_key_row;
        o_value_row  = i_value_row;
        o_wr_en      = 1'b0;
        o_flags      = '0;
        o_read_value = '0;
        unique case (i_cmd)
            CMD_PUT: begin
                o_wr_en             = hit || have_free;
                o_flags.found       = hit;
                o_flags.bucket_full = !hit && !have_free;
                for (int w = 0; w < WAYS; w++) begin
                    if (hit_oh[w]) begin
                        o_value_row[w] = i_value;
                    end else if (!hit && free_oh[w]) begin
                        o_valid_row[w] = 1'b1;
                        o_key_row[w]   = i_key;
                        o_value_row[w] = i_value;
                    end
                end
            end
            CMD_GET: begin
                o_flags.found = hit;
                o_read_value  = hit_value;
            end
            CMD_REMOVE: begin
                o_wr_en       = hit;
                o_flags.found = hit;
                for (int w = 0; w < WAYS; w++) begin
                    if (hit_oh[w]) begin
                        o_valid_row[w] = 1'b0;
                    end
                end
            end
            CMD_NOP: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench;
    import bhm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUCKETS = 4096;
    localparam int WAYS        = 4;
    localparam int KEY_BITS    = 20;
    localparam int VALUE_BITS  = 20;
    localparam int SLOTS       = NUM_BUCKETS * WAYS;
    localparam int BKT_BITS    = $clog2(NUM_BUCKETS);
    localparam int HI_BITS     = KEY_BITS - BKT_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
        logic                  bucket_full;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_cmd = CMD_NOP;
    logic [KEY_BITS-1:0]   i_key = '0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_found;
    logic [VALUE_BITS-1:0] o_read_value;
    logic                  o_bucket_full;

    // shadow copy of the table
    bit                    shadow_valid [SLOTS];
    logic [KEY_BITS-1:0]   shadow_key   [SLOTS];
    logic [VALUE_BITS-1:0] shadow_value [SLOTS];

    t_outcome              outcome_q [$];
    logic [KEY_BITS-1:0]   stored_keys [$];
    logic [BKT_BITS-1:0]   hot_bkt [8];
    logic [HI_BITS-1:0]    hot_hi [6];

    int error_count = 0;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int rx_left = 0;

    bucketed_hash_map #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_bucket_full (o_bucket_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    function automatic t_outcome table_apply(t_cmd cmd, logic [KEY_BITS-1:0] key,
                                             logic [VALUE_BITS-1:0] val);
        int base;
        int hit_slot;
        int free_slot;
        bit hit;
        bit have_free;
        t_outcome res;
        base = (key % NUM_BUCKETS) * WAYS;
        hit = 1'b0;
        have_free = 1'b0;
        hit_slot = 0;
        free_slot = 0;
        res = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (shadow_valid[base + w]) begin
                if (!hit && shadow_key[base + w] == key) begin
                    hit = 1'b1;
                    hit_slot = base + w;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_slot = base + w;
            end
        end
        case (cmd)
            CMD_PUT: begin
                if (hit) begin
                    shadow_value[hit_slot] = val;
                    res.found = 1'b1;
                end else if (have_free) begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_key[free_slot] = key;
                    shadow_value[free_slot] = val;
                end else begin
                    res.bucket_full = 1'b1;
                end
            end
            CMD_GET: begin
                if (hit) begin
                    res.found = 1'b1;
                    res.read_value = shadow_value[hit_slot];
                end
            end
            CMD_REMOVE: begin
                if (hit) begin
                    res.found = 1'b1;
                    shadow_valid[hit_slot] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // offer one command, return at the edge where the transfer happens
    task automatic send_op(t_cmd cmd, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] val);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        i_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        outcome_q.push_back(table_apply(cmd, key, val));
        if (cmd == CMD_PUT) begin
            stored_keys.push_back(key);
            if (stored_keys.size() > 64) void'(stored_keys.pop_front());
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outcome_q.size() != 0);
    endtask

    function automatic logic [KEY_BITS-1:0] hot_key();
        return {hot_hi[$urandom_range(0, 5)], hot_bkt[$urandom_range(0, 7)]};
    endfunction

    task automatic send_random();
        int roll;
        t_cmd cmd;
        logic [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0] val;
        roll = $urandom_range(0, 99);
        val = VALUE_BITS'($urandom);
        if (roll < 10) begin
            // noise: any command, any key
            cmd = t_cmd'($urandom_range(0, 3));
            key = KEY_BITS'($urandom);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      cmd = CMD_PUT;
            else if (roll < 75) cmd = CMD_GET;
            else if (roll < 95) cmd = CMD_REMOVE;
            else                cmd = CMD_NOP;
            if (cmd != CMD_PUT && stored_keys.size() != 0 && $urandom_range(0, 3) != 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else
                key = hot_key();
        end
        send_op(cmd, key, val);
    endtask

    task automatic test_put_get_remove();
        logic [KEY_BITS-1:0] k;
        k = {HI_BITS'(8'h3c), BKT_BITS'(12'h5a3)};
        send_op(CMD_GET, k, 20'h12345);
        send_op(CMD_REMOVE, k, 20'h0);
        send_op(CMD_PUT, k, 20'haaaaa);
        send_op(CMD_GET, k, 20'h0);
        send_op(CMD_PUT, k, 20'h55555);
        send_op(CMD_GET, k, 20'hfffff);
        send_op(CMD_NOP, 20'hfffff, 20'hfffff);
        send_op(CMD_NOP, k, 20'h0);
    endtask

    task automatic test_bucket_overflow();
        logic [BKT_BITS-1:0] b;
        b = 12'h5a3;
        send_op(CMD_PUT, {HI_BITS'(8'h01), b}, 20'h00001);
        send_op(CMD_PUT, {HI_BITS'(8'h02), b}, 20'h00002);
        send_op(CMD_PUT, {HI_BITS'(8'h03), b}, 20'h00003);
        send_op(CMD_PUT, {HI_BITS'(8'h04), b}, 20'h00004);
        send_op(CMD_GET, {HI_BITS'(8'h04), b}, 20'h0);
        send_op(CMD_REMOVE, {HI_BITS'(8'h01), b}, 20'h0);
        send_op(CMD_PUT, {HI_BITS'(8'h04), b}, 20'h00004);
        send_op(CMD_GET, {HI_BITS'(8'h04), b}, 20'h0);
        send_op(CMD_REMOVE, {HI_BITS'(8'h3c), b}, 20'h0);
        send_op(CMD_GET, {HI_BITS'(8'h3c), b}, 20'h0);
    endtask

    task automatic test_extremes();
        send_op(CMD_PUT, '0, '0);
        send_op(CMD_GET, '0, '1);
        send_op(CMD_PUT, '1, '1);
        send_op(CMD_GET, '1, '0);
        send_op(CMD_REMOVE, '1, '1);
        send_op(CMD_GET, '1, '1);
    endtask

    task automatic test_random_mix(int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_random();
    endtask

    task automatic test_backpressure();
        hold_requests++;
        repeat (60) send_random();
    endtask

    task automatic test_drain_pause();
        repeat (80) send_random();
        wait_for_results();
        repeat (80) send_random();
    endtask

    task automatic test_no_idling();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (250) send_random();
    endtask

    // receiver side: random stall bursts and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_left <= 0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            rx_left <= $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
            rx_left <= $urandom_range(0, 6);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_found), 32'd0);
            end else begin
                want = outcome_q.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", 32'(o_read_value), 32'(want.read_value));
                if (o_bucket_full !== want.bucket_full)
                    report_mismatch("bucket_full", 32'(o_bucket_full),
                                    32'(want.bucket_full));
            end
        end
    end

    initial begin
        int waited;
        for (int s = 0; s < SLOTS; s++) begin
            shadow_valid[s] = 1'b0;
            shadow_key[s] = '0;
            shadow_value[s] = '0;
        end
        hot_bkt[0] = '0;
        hot_bkt[1] = '1;
        for (int i = 2; i < 8; i++) hot_bkt[i] = BKT_BITS'($urandom);
        hot_hi[0] = '0;
        hot_hi[1] = '1;
        for (int i = 2; i < 6; i++) hot_hi[i] = HI_BITS'($urandom);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_put_get_remove();
        test_bucket_overflow();
        test_extremes();
        test_random_mix(1000);
        test_backpressure();
        test_drain_pause();
        test_no_idling();

        i_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (outcome_q.size() != 0 && waited < DRAIN_LIMIT);
        if (outcome_q.size() != 0)
            report_mismatch("results never arrived", outcome_q.size(), 32'd0);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
